// ===== sv/xrng_pkg.sv =====
// ----------------------------------------------------------------------------
// xrng_pkg
// Types and constants shared by the xoshiro128+ generator: the request and
// response payloads, operation codes, splitmix64 constants and the command
// bundle from the controller to the datapath.
// ----------------------------------------------------------------------------
package xrng_pkg;

   // Operation codes carried in a request.
   localparam logic OP_DRAW   = 1'b0;
   localparam logic OP_RESEED = 1'b1;

   // splitmix64 constants.
   localparam logic [63:0] GOLDEN_STEP = 64'h9e37_79b9_7f4a_7c15;
   localparam logic [63:0] MIX_MUL_A   = 64'hbf58_476d_1ce4_e5b9;
   localparam logic [63:0] MIX_MUL_B   = 64'h94d0_49bb_1331_11eb;

   localparam int unsigned SHIFT_PRE   = 30;
   localparam int unsigned SHIFT_MID   = 27;
   localparam int unsigned SHIFT_POST  = 31;

   // xoshiro128 update constants.
   localparam int unsigned XOSHIRO_SHL = 9;
   localparam int unsigned XOSHIRO_ROT = 11;

   localparam int unsigned WORD_COUNT  = 4;

   typedef struct packed {
      logic        operation;
      logic [63:0] seed_value;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] random_word;
      logic [23:0] unit_fraction;
   } rsp_payload_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load_acc;     // load the seed accumulator
      logic       seed_zero;    // load zero instead of the request seed
      logic       golden_step;  // add the golden constant and pre-mix
      logic       mul_en;       // one step of the split 64-bit multiply
      logic [1:0] mul_step;
      logic       const_b;      // second mixing multiplier selected
      logic       mix_shift;    // middle xor-shift into the multiplier operand
      logic       store_word;   // final xor-shift into a state word
      logic [1:0] word_index;
      logic       draw;         // produce a word and advance the state
      logic       reply_zero;   // load the zero response of a reseed
   } xrng_cmd_type;

endpackage

// ===== sv/xrng_stream_if.sv =====
// ----------------------------------------------------------------------------
// xrng_stream_if
// Valid/ready channel carrying one payload per request.
// ----------------------------------------------------------------------------
interface xrng_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/xrng_datapath.sv =====
// ----------------------------------------------------------------------------
// xrng_datapath
// State words, splitmix64 seeding arithmetic on a shared 32x32 multiplier,
// the xoshiro128+ draw and the response register.
// ----------------------------------------------------------------------------
module xrng_datapath
   import xrng_pkg::*;
(
   input  logic         clock,
   input  xrng_cmd_type cmd,
   input  logic [63:0]  seed_value,
   output logic [31:0]  random_word,
   output logic [23:0]  unit_fraction
);

   logic [63:0] acc_ff, acc_in;
   logic [63:0] z_ff, z_in;
   logic [63:0] mul_ff;
   logic [63:0] res_ff, res_in;
   logic [31:0] words_ff [WORD_COUNT];
   logic [31:0] words_in [WORD_COUNT];
   logic [31:0] word_ff, word_in;

   logic [63:0] acc_sum;
   logic [63:0] mul_const;
   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [63:0] product;
   logic [63:0] res_mid;
   logic [63:0] res_post;
   logic [31:0] draw_sum;
   logic [31:0] w0_n, w1_n, w2_n, w3_n;

   assign acc_sum   = acc_ff + GOLDEN_STEP;
   assign mul_const = cmd.const_b ? MIX_MUL_B : MIX_MUL_A;

   // The low 64 bits of the 64x64 product are built from three partial
   // products: lo*lo in full, then the low halves of hi*lo and lo*hi.
   assign mul_a   = (cmd.mul_step == 2'd1) ? z_ff[63:32] : z_ff[31:0];
   assign mul_b   = (cmd.mul_step == 2'd2) ? mul_const[63:32] : mul_const[31:0];
   assign product = 64'(mul_a) * 64'(mul_b);

   assign res_mid  = res_ff ^ (res_ff >> SHIFT_MID);
   assign res_post = res_ff ^ (res_ff >> SHIFT_POST);

   assign draw_sum = words_ff[0] + words_ff[3];

   always_comb begin
      logic [31:0] t2;
      logic [31:0] t3;
      t2   = words_ff[2] ^ words_ff[0];
      t3   = words_ff[3] ^ words_ff[1];
      w1_n = words_ff[1] ^ t2;
      w0_n = words_ff[0] ^ t3;
      w2_n = t2 ^ (words_ff[1] << XOSHIRO_SHL);
      w3_n = {t3[31-XOSHIRO_ROT:0], t3[31:32-XOSHIRO_ROT]};
   end

   always_comb begin
      acc_in = acc_ff;
      z_in   = z_ff;
      res_in = res_ff;
      if (cmd.load_acc) begin
         acc_in = cmd.seed_zero ? 64'd0 : seed_value;
      end else if (cmd.golden_step) begin
         acc_in = acc_sum;
         z_in   = acc_sum ^ (acc_sum >> SHIFT_PRE);
      end else if (cmd.mix_shift) begin
         z_in = res_mid;
      end
      if (cmd.mul_en) begin
         case (cmd.mul_step)
            2'd1:    res_in = mul_ff;
            2'd2,
            2'd3:    res_in = {res_ff[63:32] + mul_ff[31:0], res_ff[31:0]};
            default: res_in = res_ff;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < WORD_COUNT; i++) begin
         words_in[i] = words_ff[i];
      end
      if (cmd.store_word) begin
         words_in[cmd.word_index] = res_post[31:0];
      end else if (cmd.draw) begin
         words_in[0] = w0_n;
         words_in[1] = w1_n;
         words_in[2] = w2_n;
         words_in[3] = w3_n;
      end
      word_in = word_ff;
      if (cmd.draw) begin
         word_in = draw_sum;
      end else if (cmd.reply_zero) begin
         word_in = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      z_ff    <= z_in;
      mul_ff  <= product;
      res_ff  <= res_in;
      word_ff <= word_in;
      for (int i = 0; i < WORD_COUNT; i++) begin
         words_ff[i] <= words_in[i];
      end
   end

   assign random_word   = word_ff;
   assign unit_fraction = word_ff[31:8];

endmodule

// ===== sv/xrng_ctrl.sv =====
// ----------------------------------------------------------------------------
// xrng_ctrl
// Sequencer for the generator: request and response handshakes, the
// seeding schedule of four splitmix64 rounds and the seeding pass after reset.
// ----------------------------------------------------------------------------
module xrng_ctrl
   import xrng_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_operation,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output xrng_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_ADD,
      S_MUL,
      S_XS,
      S_REPLY
   } state_type;

   state_type  state_ff;
   logic [1:0] step_ff;
   logic [1:0] round_ff;
   logic       mix_ff;
   logic       init_ff;
   logic       rsp_valid_ff;

   logic       slot_free;
   logic       accept;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd             = '0;
      cmd.load_acc    = (state_ff == S_INIT) || (accept && req_operation == OP_RESEED);
      cmd.seed_zero   = (state_ff == S_INIT);
      cmd.golden_step = (state_ff == S_ADD);
      cmd.mul_en      = (state_ff == S_MUL);
      cmd.mul_step    = step_ff;
      cmd.const_b     = mix_ff;
      cmd.mix_shift   = (state_ff == S_XS) && !mix_ff;
      cmd.store_word  = (state_ff == S_XS) && mix_ff;
      cmd.word_index  = round_ff;
      cmd.draw        = accept && req_operation == OP_DRAW;
      cmd.reply_zero  = (state_ff == S_REPLY) && slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         step_ff      <= 2'd0;
         round_ff     <= 2'd0;
         mix_ff       <= 1'b0;
         init_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.draw || cmd.reply_zero) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_INIT: begin
               round_ff <= 2'd0;
               mix_ff   <= 1'b0;
               step_ff  <= 2'd0;
               state_ff <= S_ADD;
            end
            S_IDLE: begin
               if (accept && req_operation == OP_RESEED) begin
                  init_ff  <= 1'b0;
                  round_ff <= 2'd0;
                  mix_ff   <= 1'b0;
                  step_ff  <= 2'd0;
                  state_ff <= S_ADD;
               end
            end
            S_ADD: begin
               state_ff <= S_MUL;
            end
            S_MUL: begin
               step_ff <= step_ff + 2'd1;
               if (step_ff == 2'd3) begin
                  state_ff <= S_XS;
               end
            end
            S_XS: begin
               if (!mix_ff) begin
                  mix_ff   <= 1'b1;
                  state_ff <= S_MUL;
               end else begin
                  mix_ff   <= 1'b0;
                  round_ff <= round_ff + 2'd1;
                  if (round_ff == 2'(WORD_COUNT - 1)) begin
                     // The pass after reset gives no response.
                     state_ff <= init_ff ? S_IDLE : S_REPLY;
                  end else begin
                     state_ff <= S_ADD;
                  end
               end
            end
            S_REPLY: begin
               if (slot_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== sv/xoshiro128plus_generator.sv =====
// A draw request's response is registered at acceptance and is valid in the
// next cycle, and draws are accepted every cycle while the response side keeps
// taking them. A reseed runs four splitmix64 rounds on one shared 32x32
// multiplier; its zero response is registered in S_REPLY once the response
// slot is free. After reset the state is seeded from zero by the same
// sequencer, so no request is accepted until that seeding pass has finished.
// ----------------------------------------------------------------------------
// xoshiro128plus_generator
// xoshiro128+ random word generator with splitmix64 seeding.
// ----------------------------------------------------------------------------
module xoshiro128plus_generator
   import xrng_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   xrng_stream_if.sink   req_chan,
   xrng_stream_if.source rsp_chan
);

   xrng_cmd_type cmd;
   logic [31:0]  random_word;
   logic [23:0]  unit_fraction;

   xrng_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_operation (req_chan.payload.operation),
      .req_ready     (req_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .cmd           (cmd)
   );

   xrng_datapath u_datapath (
      .clock         (clock),
      .cmd           (cmd),
      .seed_value    (req_chan.payload.seed_value),
      .random_word   (random_word),
      .unit_fraction (unit_fraction)
   );

   assign rsp_chan.payload.random_word   = random_word;
   assign rsp_chan.payload.unit_fraction = unit_fraction;

endmodule

// ===== tb/xoshiro128plus_generator_test.sv =====
// ----------------------------------------------------------------------------
// xoshiro128plus_generator_test
// Self-checking bench for the xoshiro128+ generator. Draw and reseed requests
// are queued up front and offered with random gaps, responses are taken with
// random stalls and one long hold-off, and every response is checked against
// a local model of the splitmix64 seeding and the xoshiro128+ update.
// ----------------------------------------------------------------------------
module xoshiro128plus_generator_test
   import xrng_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT  = 600000;
   localparam int unsigned RANDOM_ITEMS = 2000;
   localparam int unsigned HOLD_AT      = 500;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned DRAIN_CYCLES = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;

   xrng_stream_if #(.payload_type(req_payload_type)) req_if ();
   xrng_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   logic            req_valid   = 1'b0;
   req_payload_type req_payload = '0;
   logic            rsp_ready   = 1'b0;

   assign req_if.valid   = req_valid;
   assign req_if.payload = req_payload;
   assign rsp_if.ready   = rsp_ready;

   xoshiro128plus_generator i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // Local copy of the generator state.
   logic [31:0] gen_words [WORD_COUNT];

   req_payload_type pending_requests [$];
   rsp_payload_type expected_rsp [$];

   int unsigned error_count    = 0;
   int unsigned accepted_count = 0;
   int unsigned draw_count     = 0;
   int unsigned reseed_count   = 0;
   int unsigned checked_count  = 0;
   int unsigned cycle_count    = 0;
   int unsigned hold_left      = 0;
   logic        hold_done      = 1'b0;

   // A window in the middle of the run in which neither side idles.
   wire calm = (accepted_count >= 1000) && (accepted_count < 1400);

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic void splitmix_fill(input logic [63:0] seed);
      logic [63:0] acc;
      logic [63:0] z;
      acc = seed;
      for (int i = 0; i < WORD_COUNT; i++) begin
         acc = acc + GOLDEN_STEP;
         z = acc;
         z = (z ^ (z >> SHIFT_PRE)) * MIX_MUL_A;
         z = (z ^ (z >> SHIFT_MID)) * MIX_MUL_B;
         z = z ^ (z >> SHIFT_POST);
         gen_words[i] = z[31:0];
      end
   endfunction

   function automatic logic [31:0] xoshiro_next();
      logic [31:0] w0, w1, w2, w3, sum, shifted;
      w0 = gen_words[0];
      w1 = gen_words[1];
      w2 = gen_words[2];
      w3 = gen_words[3];
      sum = w0 + w3;
      shifted = w1 << XOSHIRO_SHL;
      w2 = w2 ^ w0;
      w3 = w3 ^ w1;
      w1 = w1 ^ w2;
      w0 = w0 ^ w3;
      w2 = w2 ^ shifted;
      w3 = (w3 << XOSHIRO_ROT) | (w3 >> (32 - XOSHIRO_ROT));
      gen_words[0] = w0;
      gen_words[1] = w1;
      gen_words[2] = w2;
      gen_words[3] = w3;
      return sum;
   endfunction

   function automatic void predict_response(input req_payload_type r);
      rsp_payload_type e;
      e = '0;
      if (r.operation == OP_RESEED) begin
         splitmix_fill(r.seed_value);
      end else begin
         e.random_word = xoshiro_next();
         e.unit_fraction = e.random_word[31:8];
      end
      expected_rsp.push_back(e);
   endfunction

   function automatic void add_request(input logic op, input logic [63:0] seed);
      req_payload_type r;
      r.operation = op;
      r.seed_value = seed;
      pending_requests.push_back(r);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("[%0t] mismatch on response %0d: %s got %h expected %h",
               $realtime, checked_count, what, got, want);
      error_count++;
   endtask

   // Request driver.
   always @(posedge clock) begin : request_driver
      logic fire;
      fire = req_valid && req_if.ready;
      if (reset) begin
         req_valid <= 1'b0;
         splitmix_fill('0);
      end else begin
         if (fire) begin
            predict_response(req_payload);
            if (req_payload.operation == OP_RESEED) begin
               reseed_count++;
            end else begin
               draw_count++;
            end
            void'(pending_requests.pop_front());
            accepted_count <= accepted_count + 1;
         end
         if (!req_valid || fire) begin
            if (pending_requests.size() != 0 && (calm || $urandom_range(99) >= 15)) begin
               req_valid <= 1'b1;
               req_payload <= pending_requests[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, started once, so that the block backs up.
   always @(posedge clock) begin
      if (!reset) begin
         if (!hold_done && accepted_count == HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
         end
      end
   end

   // Response monitor.
   always @(posedge clock) begin : response_monitor
      rsp_payload_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_ready && rsp_if.valid) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch("unexpected response, word", rsp_if.payload.random_word,
                               'x);
            end else begin
               e = expected_rsp.pop_front();
               if (rsp_if.payload.random_word !== e.random_word) begin
                  report_mismatch("random_word", rsp_if.payload.random_word,
                                  e.random_word);
               end
               if (rsp_if.payload.unit_fraction !== e.unit_fraction) begin
                  report_mismatch("unit_fraction", {8'h00, rsp_if.payload.unit_fraction},
                                  {8'h00, e.unit_fraction});
               end
            end
            checked_count++;
         end
         rsp_ready <= (hold_left == 0) && (calm || $urandom_range(99) >= 15);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d requests pending.",
                  cycle_count, pending_requests.size());
         $display("xoshiro128plus_generator_test: FAIL");
         $finish;
      end
   end

   initial begin
      logic [63:0] seed;
      int unsigned run_left;

      // Draws from the reset state, which is seeded from zero.
      repeat (4) add_request(OP_DRAW, '0);
      // The seed field of a draw is ignored.
      add_request(OP_DRAW, '1);
      add_request(OP_RESEED, '0);
      repeat (2) add_request(OP_DRAW, 64'h5555_5555_5555_5555);
      add_request(OP_RESEED, '1);
      repeat (2) add_request(OP_DRAW, '0);
      add_request(OP_RESEED, 64'h1);
      add_request(OP_DRAW, '0);
      add_request(OP_RESEED, 64'h8000_0000_0000_0000);
      add_request(OP_DRAW, '0);
      // Back-to-back reseeds: only the second one matters for later draws.
      add_request(OP_RESEED, 64'hffff_ffff_0000_0000);
      add_request(OP_RESEED, 64'h0000_0000_ffff_ffff);
      repeat (2) add_request(OP_DRAW, 64'haaaa_aaaa_aaaa_aaaa);
      // A seed that makes the first accumulator wrap to zero.
      add_request(OP_RESEED, -GOLDEN_STEP);
      repeat (2) add_request(OP_DRAW, '0);

      // Random part: reseeds followed by runs of draws with random seed fields.
      run_left = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (run_left == 0) begin
            case ($urandom_range(9))
               0:       seed = '0;
               1:       seed = '1;
               default: seed = {$urandom, $urandom};
            endcase
            add_request(OP_RESEED, seed);
            run_left = $urandom_range(40, 1);
         end else begin
            add_request(OP_DRAW, {$urandom, $urandom});
            run_left--;
         end
      end

      while (pending_requests.size() != 0 || expected_rsp.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d responses: %0d draws and %0d reseeds, with random gaps,",
               checked_count, draw_count, reseed_count);
      $display("a %0d-cycle receiver hold-off and a stretch at full rate.", HOLD_CYCLES);
      if (error_count == 0 && expected_rsp.size() == 0) begin
         $display("xoshiro128plus_generator_test: PASS");
      end else begin
         $display("%0d mismatches, %0d responses outstanding.", error_count,
                  expected_rsp.size());
         $display("xoshiro128plus_generator_test: FAIL");
      end
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

endmodule
